FILE: src/hmm_scaled_forward_step_top_macros.svh
// Assertion macros for the forward step block
`ifndef HMM_SCALED_FORWARD_STEP_TOP_MACROS_SVH
`define HMM_SCALED_FORWARD_STEP_TOP_MACROS_SVH
// Implication checked every clock, disabled during reset
`define HMM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset
`define HMM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: src/hfs_pkg.sv
// ----------------------------------------------------------------------------
// hfs_pkg
// Shared types and constants of the scaled forward step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package hfs_pkg;
	localparam int MAX_CLASSES = 8;
	localparam int PROB_BITS   = 16;
	localparam int CW          = $clog2(MAX_CLASSES);
	localparam int SUM_BITS    = PROB_BITS + CW;
	localparam int NUM_BITS    = SUM_BITS;
	localparam int TOT_BITS    = NUM_BITS + CW;
	localparam int DCW         = $clog2(PROB_BITS + 1);

	localparam logic [1:0] CMD_TRANS = 2'd0;
	localparam logic [1:0] CMD_INIT  = 2'd1;
	localparam logic [1:0] CMD_EMIT  = 2'd2;

	typedef struct packed {
		logic          start;
		logic          first;
		logic [CW-1:0] last_idx;
	} hfs_cmd_t;

	typedef struct packed {
		logic done;
	} hfs_stat_t;
endpackage

FILE: src/hfs_datapath.sv
// ----------------------------------------------------------------------------
// hfs_datapath
// Tables, multiply-accumulate, normalising divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hmm_scaled_forward_step_top_macros.svh"
module hfs_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [1:0]                       command,
	input  logic [2:0]                       from_class,
	input  logic [2:0]                       to_class,
	input  logic [hfs_pkg::PROB_BITS-1:0]    prob_value,
	input  hfs_pkg::hfs_cmd_t                cmd,
	output hfs_pkg::hfs_stat_t               stat,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       out_class,
	output logic [hfs_pkg::PROB_BITS-1:0]    forward_value,
	output logic                             zero_total,
	output logic                             last_of_step
);
	import hfs_pkg::*;

	typedef enum logic [5:0] {
		P_IDLE = 6'b000001, P_MAC = 6'b000010, P_NUM = 6'b000100,
		P_DIV = 6'b001000, P_OUT = 6'b010000, P_WAIT = 6'b100000
	} ph_t;

	logic [PROB_BITS-1:0] trans_mem [MAX_CLASSES*MAX_CLASSES];
	logic [PROB_BITS-1:0] init_q [MAX_CLASSES];
	logic [PROB_BITS-1:0] prev_q [MAX_CLASSES];
	logic [PROB_BITS-1:0] emis_q [MAX_CLASSES];
	logic [NUM_BITS-1:0]  num_q [MAX_CLASSES];

	ph_t                  ph_q;
	logic                 first_q;
	logic [CW-1:0]        last_q, j_q, x_q;
	logic [PROB_BITS-1:0] tr_rd_q;
	logic                 rd_ok_q;
	logic [SUM_BITS-1:0]  sum_q;
	logic [TOT_BITS-1:0]  tot_q;
	logic [TOT_BITS:0]    rem_q;
	logic [PROB_BITS-1:0] quo_q;
	logic [DCW-1:0]       bit_q;
	logic                 ovf_q, ovf_prev_q;
	logic [(2*PROB_BITS)-1:0] prod;
	logic [SUM_BITS+PROB_BITS-1:0] nprod;
	logic [TOT_BITS:0]    rsh;
	logic                 acc_ok;

	assign acc_ok = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (acc_ok && command == CMD_TRANS)
			trans_mem[{from_class[CW-1:0], to_class[CW-1:0]}] <= prob_value;
		tr_rd_q <= trans_mem[{x_q, j_q}];
		if (acc_ok && command == CMD_INIT)
			init_q[to_class[CW-1:0]] <= prob_value;
		if (acc_ok && command == CMD_EMIT)
			emis_q[to_class[CW-1:0]] <= prob_value;
	end

	assign prod  = tr_rd_q * prev_q[x_q];
	assign nprod = (first_q ? {{CW{1'b0}}, init_q[j_q]} : sum_q) * emis_q[j_q];
	assign rsh   = {rem_q[TOT_BITS-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= P_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && ph_q != P_OUT)
				out_valid <= 1'b0;
			case (ph_q)
				P_IDLE: begin
					if (cmd.start) begin
						first_q <= cmd.first;
						last_q  <= cmd.last_idx;
						j_q     <= '0;
						x_q     <= '0;
						sum_q   <= '0;
						tot_q   <= '0;
						rd_ok_q <= 1'b0;
						ovf_prev_q <= 1'b0;
						ph_q    <= cmd.first ? P_NUM : P_MAC;
					end
				end
				P_MAC: begin
					if (!rd_ok_q) begin
						rd_ok_q <= 1'b1;
					end else begin
						sum_q   <= sum_q + SUM_BITS'(prod[2*PROB_BITS-1:PROB_BITS]);
						rd_ok_q <= 1'b0;
						if (x_q == last_q) begin
							x_q  <= '0;
							ph_q <= P_NUM;
						end else begin
							x_q <= x_q + 1'b1;
						end
					end
				end
				P_NUM: begin
					num_q[j_q] <= nprod[SUM_BITS+PROB_BITS-1:PROB_BITS];
					tot_q <= tot_q + TOT_BITS'(nprod[SUM_BITS+PROB_BITS-1:PROB_BITS]);
					sum_q <= '0;
					if (j_q == last_q) begin
						j_q  <= '0;
						ph_q <= P_DIV;
						bit_q <= '0;
					end else begin
						j_q  <= j_q + 1'b1;
						ph_q <= first_q ? P_NUM : P_MAC;
					end
				end
				P_DIV: begin
					if (bit_q == '0) begin
						rem_q <= {1'b0, TOT_BITS'(num_q[j_q])};
						quo_q <= '0;
						ovf_q <= TOT_BITS'(num_q[j_q]) >= tot_q;
						bit_q <= bit_q + 1'b1;
					end else begin
						if (rsh >= {1'b0, tot_q}) begin
							rem_q <= rsh - {1'b0, tot_q};
							quo_q <= {quo_q[PROB_BITS-2:0], 1'b1};
						end else begin
							rem_q <= rsh;
							quo_q <= {quo_q[PROB_BITS-2:0], 1'b0};
						end
						if (bit_q == DCW'(PROB_BITS))
							ph_q <= P_OUT;
						else
							bit_q <= bit_q + 1'b1;
					end
				end
				P_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid     <= 1'b1;
						out_class     <= 3'(j_q);
						zero_total    <= tot_q == '0;
						last_of_step  <= j_q == last_q;
						if (tot_q == '0)
							forward_value <= '0;
						else if (ovf_q)
							forward_value <= '1;
						else
							forward_value <= quo_q;
						prev_q[j_q] <= (tot_q == '0) ? '0 : (ovf_q ? '1 : quo_q);
						bit_q <= '0;
						if (j_q == last_q) begin
							ph_q <= P_WAIT;
						end else begin
							j_q  <= j_q + 1'b1;
							ph_q <= P_DIV;
						end
					end
				end
				P_WAIT: begin
					if (!out_valid || !out_stall)
						ph_q <= P_IDLE;
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	assign stat.done = (ph_q == P_WAIT) && (!out_valid || !out_stall);

	`HMM_ASSERT_IMP(a_out_hold, out_valid && out_stall, ph_q != P_IDLE || out_valid,
		"output lost while stalled")
	`HMM_ASSERT_NXT(a_start_leaves_idle, ph_q == P_IDLE && cmd.start, ph_q != P_IDLE,
		"start ignored")
	`HMM_ASSERT_IMP(a_done_wait, stat.done, ph_q == P_WAIT, "done outside wait")
endmodule

FILE: src/hfs_ctrl.sv
// ----------------------------------------------------------------------------
// hfs_ctrl
// Input handshake, class count register and step sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hmm_scaled_forward_step_top_macros.svh"
module hfs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [2:0]         to_class,
	input  logic               seq_start,
	output hfs_pkg::hfs_cmd_t  cmd,
	input  hfs_pkg::hfs_stat_t stat
);
	import hfs_pkg::*;

	typedef enum logic [1:0] { S_IDLE = 2'b01, S_BUSY = 2'b10 } st_t;

	st_t        st_q;
	logic [3:0] ncls_q;
	logic       first_q;
	logic [CW-1:0] last;
	logic       acc, fire;

	always_comb begin
		if (ncls_q == 4'd0)
			last = '0;
		else if (ncls_q > 4'(MAX_CLASSES))
			last = CW'(MAX_CLASSES - 1);
		else
			last = CW'(ncls_q - 4'd1);
	end

	assign in_stall = st_q != S_IDLE;
	assign acc      = in_valid && !in_stall;
	assign fire     = acc && command == CMD_EMIT && to_class[CW-1:0] == last;

	assign cmd.start    = fire;
	assign cmd.first    = first_q || seq_start;
	assign cmd.last_idx = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			ncls_q  <= 4'd8;
			first_q <= 1'b0;
		end else begin
			if (cfg_we)
				ncls_q <= cfg_wdata;
			case (st_q)
				S_IDLE: begin
					if (fire) begin
						st_q    <= S_BUSY;
						first_q <= 1'b0;
					end else if (acc && command == CMD_EMIT && seq_start) begin
						first_q <= 1'b1;
					end
				end
				S_BUSY: if (stat.done) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`HMM_ASSERT_IMP(a_no_acc_busy, st_q == S_BUSY, in_stall, "item taken while busy")
	`HMM_ASSERT_NXT(a_fire_busy, fire, st_q == S_BUSY && !first_q, "step not started")
	`HMM_ASSERT_IMP(a_done_busy, stat.done, st_q == S_BUSY, "done while idle")
endmodule

FILE: src/hmm_scaled_forward_step_top.sv
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_top
// Scaled forward recursion step of a hidden Markov model, Q0.16.
// ----------------------------------------------------------------------------
// Use: the input channel (in_valid/in_stall) carries load commands and
// emission items; the output channel (out_valid/out_stall) carries one item
// per class in use after the emission for the last class arrives.
// Load and non-closing emission items never raise in_stall.
// A closing item of K classes keeps in_stall high through the shared
// multiply-accumulate (skipped on a sequence start), the bit-serial
// divider, which yields one bit a cycle, and the output handoff.
// The first result appears after the accumulation and first division.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the sequencer and sets the class count to 8; tables are
// undefined until loaded. cfg_we writes the class count; the user must
// write it only while idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hmm_scaled_forward_step_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  from_class,
	input  logic [2:0]  to_class,
	input  logic [15:0] prob_value,
	input  logic        seq_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  out_class,
	output logic [15:0] forward_value,
	output logic        zero_total,
	output logic        last_of_step
);
	import hfs_pkg::*;

	hfs_cmd_t  cmd;
	hfs_stat_t stat;

	hfs_ctrl u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
		.command, .to_class, .seq_start, .cmd, .stat
	);

	hfs_datapath u_dp (
		.clk, .arst_n, .in_valid, .in_stall, .command, .from_class, .to_class,
		.prob_value, .cmd, .stat, .out_valid, .out_stall, .out_class,
		.forward_value, .zero_total, .last_of_step
	);
endmodule
